[design/assert_macros.svh]
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/asl_pkg.sv]
// Shared types and constants of the averaging sample logger.
`timescale 1ns / 1ps

package asl_pkg;

    localparam int CHANNELS     = 4;
    localparam int SAMPLE_BITS  = 16;
    localparam int SUM_BITS     = 26;
    localparam int CFG_BITS     = 11;
    localparam int COUNT_BITS   = 10;
    localparam int RIDX_BITS    = 10;
    localparam int DIV_STEPS    = 26;
    localparam int DIV_CNT_BITS = 5;

    localparam logic [CFG_BITS-1:0] AVG_RESET      = 11'd20;
    localparam logic [CFG_BITS-1:0] AVG_MAX        = 11'd1024;
    localparam logic [CFG_BITS-1:0] LOG_SIZE_RESET = 11'd1024;

    typedef enum logic [1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_ENABLE  = 2'd1,
        CMD_DISABLE = 2'd2,
        CMD_READ    = 2'd3
    } t_cmd;

    typedef enum logic [0:0] {
        CFG_AVERAGE_COUNT = 1'b0,
        CFG_LOG_SIZE      = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_COMMIT,
        ST_RESULT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic exec;
        logic div_load;
        logic div_step;
        logic commit;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_cmd cmd;
        logic take;
        logic roll;
        logic div_done;
    } t_dp_status;

endpackage

[design/asl_datapath.sv]
// Datapath: sums, restoring dividers, log memory, flags and result register.
`timescale 1ns / 1ps

module asl_datapath #(
    parameter int LOG_DEPTH = 1024
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  asl_pkg::t_dp_cmd                                   i_cmd,
    output asl_pkg::t_dp_status                                o_status,
    input  asl_pkg::t_cmd                                      i_in_command,
    input  logic [asl_pkg::CHANNELS-1:0][asl_pkg::SAMPLE_BITS-1:0] i_in_samples,
    input  logic [asl_pkg::RIDX_BITS-1:0]                      i_in_read_index,
    input  logic                                               i_cfg_write,
    input  asl_pkg::t_cfg_idx                                  i_cfg_index,
    input  logic [asl_pkg::CFG_BITS-1:0]                       i_cfg_data,
    output logic [asl_pkg::CHANNELS-1:0][asl_pkg::SAMPLE_BITS-1:0] o_read_ch,
    output logic                                               o_log_enabled,
    output logic                                               o_log_full,
    output logic                                               o_wants_samples
);
    import asl_pkg::*;

    localparam int AW = $clog2(LOG_DEPTH);
    localparam int CW = $clog2(LOG_DEPTH + 1);
    localparam int SW = (CW > CFG_BITS) ? CW : CFG_BITS;
    localparam int XW = (CW > RIDX_BITS) ? CW : RIDX_BITS;

    // Captured item
    t_cmd                                   r_cmd;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0]   r_samp;
    logic [RIDX_BITS-1:0]                   r_ridx;

    // Configuration
    logic [CFG_BITS-1:0] r_avg_cnt;
    logic [CFG_BITS-1:0] r_log_size;

    // Logger state
    logic [CHANNELS-1:0][SUM_BITS-1:0] r_sum;
    logic [COUNT_BITS-1:0]             r_count;
    logic [CW-1:0]                     r_wr_idx;
    logic [CW-1:0]                     r_fill;
    logic                              r_armed;
    logic                              r_full;

    // Dividers
    logic [CFG_BITS-1:0]               r_div;
    logic [DIV_CNT_BITS-1:0]           r_div_cnt;
    logic [CHANNELS-1:0][CFG_BITS-1:0] r_rem;
    logic [CHANNELS-1:0][SUM_BITS-1:0] r_quo;
    logic [CHANNELS-1:0]               r_neg;

    // Log memory
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] r_mem [LOG_DEPTH];
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] r_rd_data;

    logic [CFG_BITS-1:0]                  w_avg_eff;
    logic [SW-1:0]                        w_size_eff;
    logic [CW-1:0]                        w_wr_next;
    logic                                 w_rd_hit;
    logic [AW-1:0]                        w_rd_addr;
    logic [AW-1:0]                        w_wr_addr;
    logic [XW-1:0]                        w_ridx_x;
    logic [CHANNELS-1:0][SUM_BITS-1:0]    w_samp_ext;
    logic [CHANNELS-1:0][SUM_BITS-1:0]    w_mag;
    logic [CHANNELS-1:0][CFG_BITS:0]      w_trial;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] w_quo_res;

    always_comb begin
        if (r_avg_cnt == '0) begin
            w_avg_eff = CFG_BITS'(1);
        end else if (r_avg_cnt > AVG_MAX) begin
            w_avg_eff = AVG_MAX;
        end else begin
            w_avg_eff = r_avg_cnt;
        end
        if (SW'(r_log_size) == '0) begin
            w_size_eff = SW'(1);
        end else if (SW'(r_log_size) > SW'(LOG_DEPTH)) begin
            w_size_eff = SW'(LOG_DEPTH);
        end else begin
            w_size_eff = SW'(r_log_size);
        end
    end

    assign w_wr_next = r_wr_idx + CW'(1);
    assign w_wr_addr = AW'(r_wr_idx);
    assign w_ridx_x  = XW'(r_ridx);
    // Entries below the fill mark have been written at least once
    assign w_rd_hit  = w_ridx_x < XW'(r_fill);
    assign w_rd_addr = AW'(w_ridx_x);

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            w_samp_ext[c] = {{(SUM_BITS-SAMPLE_BITS){r_samp[c][SAMPLE_BITS-1]}}, r_samp[c]};
            w_mag[c]      = r_sum[c][SUM_BITS-1] ? (SUM_BITS'(0) - r_sum[c]) : r_sum[c];
            w_trial[c]    = {r_rem[c], r_quo[c][SUM_BITS-1]};
            w_quo_res[c]  = r_neg[c] ? (SAMPLE_BITS'(0) - r_quo[c][SAMPLE_BITS-1:0])
                                     : r_quo[c][SAMPLE_BITS-1:0];
        end
    end

    assign o_status.cmd      = r_cmd;
    assign o_status.take     = r_armed && !r_full;
    assign o_status.roll     = (CFG_BITS'(r_count) + CFG_BITS'(1)) >= w_avg_eff;
    assign o_status.div_done = (r_div_cnt == '0);

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_samp <= i_in_samples;
            r_ridx <= i_in_read_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= CMD_SAMPLE;
        end else if (i_cmd.load_in) begin
            r_cmd <= i_in_command;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_cnt  <= AVG_RESET;
            r_log_size <= LOG_SIZE_RESET;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                CFG_AVERAGE_COUNT: r_avg_cnt  <= i_cfg_data;
                CFG_LOG_SIZE:      r_log_size <= i_cfg_data;
            endcase
        end
    end

    // Sums, count, write index, fill mark and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_count  <= '0;
            r_wr_idx <= '0;
            r_fill   <= '0;
            r_armed  <= 1'b0;
            r_full   <= 1'b0;
        end else if (i_cmd.exec) begin
            unique case (r_cmd)
                CMD_SAMPLE: begin
                    if (r_armed && !r_full) begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            r_sum[c] <= r_sum[c] + w_samp_ext[c];
                        end
                        r_count <= r_count + COUNT_BITS'(1);
                    end
                end
                CMD_ENABLE: begin
                    r_sum    <= '0;
                    r_count  <= '0;
                    r_wr_idx <= '0;
                    r_full   <= 1'b0;
                    r_armed  <= 1'b1;
                end
                CMD_DISABLE: begin
                    r_armed <= 1'b0;
                end
                CMD_READ: begin
                end
            endcase
        end else if (i_cmd.commit) begin
            r_sum    <= '0;
            r_count  <= '0;
            r_wr_idx <= w_wr_next;
            if (SW'(w_wr_next) >= w_size_eff) begin
                r_full <= 1'b1;
            end
            if (w_wr_next > r_fill) begin
                r_fill <= w_wr_next;
            end
        end
    end

    // Four restoring dividers sharing one step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_load) begin
            r_div_cnt <= DIV_CNT_BITS'(DIV_STEPS - 1);
        end else if (i_cmd.div_step && r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - DIV_CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_div <= w_avg_eff;
            for (int c = 0; c < CHANNELS; c++) begin
                r_rem[c] <= '0;
                r_quo[c] <= w_mag[c];
                r_neg[c] <= r_sum[c][SUM_BITS-1];
            end
        end else if (i_cmd.div_step) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (w_trial[c] >= {1'b0, r_div}) begin
                    r_rem[c] <= CFG_BITS'(w_trial[c] - {1'b0, r_div});
                    r_quo[c] <= {r_quo[c][SUM_BITS-2:0], 1'b1};
                end else begin
                    r_rem[c] <= w_trial[c][CFG_BITS-1:0];
                    r_quo[c] <= {r_quo[c][SUM_BITS-2:0], 1'b0};
                end
            end
        end
    end

    // Log memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_mem[w_wr_addr] <= w_quo_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            for (int c = 0; c < CHANNELS; c++) begin
                o_read_ch[c] <= (r_cmd == CMD_READ && w_rd_hit) ? r_rd_data[c] : '0;
            end
            o_log_enabled   <= r_armed;
            o_log_full      <= r_full;
            o_wants_samples <= r_armed && !r_full;
        end
    end

endmodule

[design/asl_controller.sv]
// Controller state machine: sequences each request and owns both handshakes.
`timescale 1ns / 1ps

module asl_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output asl_pkg::t_dp_cmd    o_cmd,
    input  asl_pkg::t_dp_status i_status
);
    import asl_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.cmd == CMD_SAMPLE && i_status.take && i_status.roll) begin
                    n_state = ST_DIV_LOAD;
                end else begin
                    n_state = ST_RESULT;
                end
            end
            ST_DIV_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_RESULT;
            end
            ST_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[design/averaging_sample_logger.sv]
// Top level of the four-channel averaging sample logger.
//
// Requests enter on s_axis: tuser carries the command (sample, enable and
// restart, disable, read entry); tdata carries four signed 16-bit samples and
// the read index. Every request yields exactly one result on m_axis: the four
// stored averages of a read entry (zero otherwise) and the status flags.
// Configuration (average count, log size) is written on the cfg channel,
// which is always ready; write it only while the logger is idle.
// Flow: a request is taken in the idle state; most requests pass through the
// execute state to the result state, which loads the output register, and
// the next request can be taken once the controller is back in idle. A sample
// that completes an average also passes the divider load, divider run (the
// 26-step restoring dividers on all four channels at once) and commit states.
// The next request is accepted as soon as the result sits in the output
// register, so a stalled receiver holds only the result; a second result
// waits in the controller until the output register drains.
// Reset clears the flags, sums, count, write index and the fill mark of the
// log memory; entries at or above the fill mark read back as zero, so the
// memory itself needs no clearing pass.
`timescale 1ns / 1ps

module averaging_sample_logger #(
    parameter int LOG_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] sample_ch0, [31:16] sample_ch1, [47:32] sample_ch2,
    // [63:48] sample_ch3, [73:64] read_index, [79:74] zero
    input  logic [79:0] s_axis_tdata,
    // [1:0] command
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] read_ch0, [31:16] read_ch1, [47:32] read_ch2, [63:48] read_ch3,
    // [64] log_enabled, [65] log_full, [66] wants_samples, [71:67] zero
    output logic [71:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [10:0] i_cfg_data
);
    import asl_pkg::*;

    t_dp_cmd                              w_cmd;
    t_dp_status                           w_status;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] w_samples;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] w_read_ch;
    logic                                 w_log_enabled;
    logic                                 w_log_full;
    logic                                 w_wants_samples;

    // Unpack the request; channel 0 sits in the lowest bits
    assign w_samples   = s_axis_tdata[CHANNELS*SAMPLE_BITS-1:0];
    // Configuration writes land at once
    assign o_cfg_ready = 1'b1;

    asl_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    asl_datapath #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_in_command    (t_cmd'(s_axis_tuser)),
        .i_in_samples    (w_samples),
        .i_in_read_index (s_axis_tdata[73:64]),
        .i_cfg_write     (i_cfg_valid),
        .i_cfg_index     (t_cfg_idx'(i_cfg_index)),
        .i_cfg_data      (i_cfg_data),
        .o_read_ch       (w_read_ch),
        .o_log_enabled   (w_log_enabled),
        .o_log_full      (w_log_full),
        .o_wants_samples (w_wants_samples)
    );

    // Pack the result, padding to whole bytes
    assign m_axis_tdata = {5'b0, w_wants_samples, w_log_full, w_log_enabled, w_read_ch};

endmodule

[design/asl_checker.sv]
// Port-level checker of the averaging sample logger, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module asl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);

    // A stalled result must hold
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

    // Wants-samples is armed and not full
    `ASSERT_CLK(a_wants_flag, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tdata[66] == (m_axis_tdata[64] && !m_axis_tdata[65])), "wants_samples inconsistent")

    // One request in flight: ready drops after an accepted request
    `ASSERT_CLK(a_one_request, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "second request taken while busy")

    // Nothing leaves right after reset
    `ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind averaging_sample_logger asl_checker u_asl_checker (.*);
